// File: hw/rtl/pdac_pkg.sv
`default_nettype none
package pdac_pkg;
    localparam int unsigned FB_W = 40;

    // register write indexes
    localparam logic [2:0] REG_POS_GAINS = 3'd0;
    localparam logic [2:0] REG_VEL_GAINS = 3'd1;
    localparam logic [2:0] REG_MAX_FB    = 3'd2;
    localparam logic [2:0] REG_GRAVITY   = 3'd3;
    localparam logic [2:0] REG_FEEDTHRU  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_FB,
        ST_SCALE,
        ST_SQ,
        ST_CMP,
        ST_SQRT,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic fb;
        logic scale;
        logic sq;
        logic cmp;
        logic sqrt_start;
        logic sqrt_step;
        logic div_start;
        logic div_step;
        logic div_next;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_z;
        logic ft;
        logic sq_done;
        logic need_limit;
        logic sqrt_done;
        logic div_done;
        logic div_all;
    } t_sts;
endpackage
`default_nettype wire

// File: hw/rtl/pd_position_accel_command.sv
`default_nettype none
// channel | signals                          | dir
// in      | i_in_valid/o_in_ready, 6 fields  | in
// out     | o_out_valid/i_out_ready, 4 fields| out
// cfg     | i_cfg_we, i_cfg_idx, i_cfg_data  | in
// x/y transactions: load, multiply, feedback. z: these, then output in
// feedthrough; else scale, sum of squares, compare and, when limited, a
// 32-step sqrt and three serial 62-step divides, then output.
// Results then drain one a cycle while i_out_ready is high.
// Input is held off while results wait. Reset synchronous active low.
module pd_position_accel_command
    import pdac_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_axis,
    input  wire logic [31:0] i_meas_pos,
    input  wire logic [31:0] i_meas_vel,
    input  wire logic [31:0] i_target_pos,
    input  wire logic [31:0] i_target_vel,
    input  wire logic [31:0] i_target_acc,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_out_axis,
    output logic [31:0]      o_desired_acc,
    output logic             o_was_limited,
    output logic             o_last,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [47:0] i_cfg_data
);
    logic [47:0] r_pg, r_vg;
    logic [30:0] r_lim;
    logic [31:0] r_gz;
    logic r_ft;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pg <= 48'd4398080066048;
            r_vg <= 48'd4398113620992;
            r_lim <= 31'd655360;
            r_gz <= 32'hFFF6_3333;
            r_ft <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_POS_GAINS: r_pg <= i_cfg_data;
                REG_VEL_GAINS: r_vg <= i_cfg_data;
                REG_MAX_FB:    r_lim <= i_cfg_data[30:0];
                REG_GRAVITY:   r_gz <= i_cfg_data[31:0];
                REG_FEEDTHRU:  r_ft <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    t_cmd cmd;
    t_sts sts;
    logic in_ok, busy, rdy;
    // out-of-order items are taken and dropped while idle
    assign o_in_ready = rdy;
    assign o_out_valid = busy;

    pdac_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .i_in_ok(in_ok),
        .i_out_busy(busy), .i_sts(sts), .o_in_ready(rdy), .o_cmd(cmd)
    );
    pdac_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_axis(i_axis),
        .i_meas_pos(i_meas_pos), .i_meas_vel(i_meas_vel), .i_target_pos(i_target_pos),
        .i_target_vel(i_target_vel), .i_target_acc(i_target_acc),
        .i_pos_gains(r_pg), .i_vel_gains(r_vg), .i_max_fb(r_lim), .i_gravity_z(r_gz),
        .i_feedthrough(r_ft), .i_out_taken(busy && i_out_ready), .o_in_ok(in_ok),
        .o_out_busy(busy), .o_sts(sts), .o_out_axis(o_out_axis),
        .o_desired_acc(o_desired_acc), .o_was_limited(o_was_limited), .o_last(o_last)
    );

    a_out_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_out_axis == 2'd2))) else $error("last");
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("ready");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> !o_out_valid) else $error("drain");
endmodule
`default_nettype wire

// File: hw/rtl/pdac_ctrl.sv
`default_nettype none
module pdac_ctrl
    import pdac_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_ok,
    input  wire logic i_out_busy,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output t_cmd      o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid && !i_out_busy && i_in_ok) n_state = ST_MUL;
            ST_MUL:   n_state = ST_FB;
            ST_FB:    n_state = !i_sts.is_z ? ST_IDLE : (i_sts.ft ? ST_OUT : ST_SCALE);
            ST_SCALE: n_state = ST_SQ;
            ST_SQ:    if (i_sts.sq_done) n_state = ST_CMP;
            ST_CMP:   n_state = i_sts.need_limit ? ST_SQRT : ST_OUT;
            ST_SQRT:  if (i_sts.sqrt_done) n_state = ST_DIV;
            ST_DIV:   if (i_sts.div_done && i_sts.div_all) n_state = ST_OUT;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = !i_out_busy;
                o_cmd.load = i_in_valid && !i_out_busy && i_in_ok;
            end
            ST_MUL:   o_cmd.mul = 1'b1;
            ST_FB:    o_cmd.fb = 1'b1;
            ST_SCALE: o_cmd.scale = 1'b1;
            ST_SQ:    o_cmd.sq = 1'b1;
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                o_cmd.sqrt_start = i_sts.need_limit;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                o_cmd.div_start = i_sts.sqrt_done;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_next = i_sts.div_done && !i_sts.div_all;
            end
            ST_OUT:   o_cmd.out_load = 1'b1;
            default:  ;
        endcase
    end
endmodule
`default_nettype wire

// File: hw/rtl/pdac_dp.sv
`default_nettype none
module pdac_dp
    import pdac_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic [1:0]  i_axis,
    input  wire logic [31:0] i_meas_pos,
    input  wire logic [31:0] i_meas_vel,
    input  wire logic [31:0] i_target_pos,
    input  wire logic [31:0] i_target_vel,
    input  wire logic [31:0] i_target_acc,
    input  wire logic [47:0] i_pos_gains,
    input  wire logic [47:0] i_vel_gains,
    input  wire logic [30:0] i_max_fb,
    input  wire logic [31:0] i_gravity_z,
    input  wire logic        i_feedthrough,
    input  wire logic        i_out_taken,
    output logic             o_in_ok,
    output logic             o_out_busy,
    output t_sts             o_sts,
    output logic [1:0]       o_out_axis,
    output logic [31:0]      o_desired_acc,
    output logic             o_was_limited,
    output logic             o_last
);
    logic [1:0] r_next_axis;
    logic [1:0] r_axis;
    logic signed [32:0] r_ep, r_ev;
    logic [15:0] r_kp, r_kv;
    logic signed [49:0] r_pp, r_pv;
    logic signed [FB_W-1:0] r_fb [3];
    logic signed [31:0] r_ref [3];
    logic [30:0] r_lim;
    logic signed [31:0] r_grav;
    logic r_ft;
    logic [30:0] r_mag [3];
    logic [2:0] r_neg;
    logic [1:0] r_i;
    logic [63:0] r_s;
    logic r_k;
    logic r_limited;
    logic [63:0] r_x, r_r;
    logic [5:0] r_cnt;
    logic [61:0] r_num;
    logic [61:0] r_rem;
    logic [31:0] r_q;
    logic [30:0] r_scaled [3];
    logic [31:0] r_res [3];
    logic [1:0] r_out_cnt;
    logic r_busy;

    assign o_in_ok = (i_axis == 2'd0) || (i_axis == r_next_axis);

    // feedback: floor(-(sum)/256) = ~((sum-1)>>>8)... done as floor of negated sum
    logic signed [51:0] w_sum, w_neg, w_sh;
    assign w_sum = 52'(r_pp) + 52'(r_pv);
    assign w_neg = -w_sum;
    assign w_sh  = w_neg >>> 8;

    logic [39:0] w_mx;
    logic [FB_W-1:0] w_abs [3];
    always_comb begin
        for (int j = 0; j < 3; j++)
            w_abs[j] = r_fb[j][FB_W-1] ? 40'(-r_fb[j]) : 40'(r_fb[j]);
        w_mx = w_abs[0] | w_abs[1] | w_abs[2];
    end
    logic [3:0] w_k;
    always_comb begin
        w_k = 4'd0;
        for (int b = 31; b < 40; b++)
            if (w_mx[b]) w_k = 4'(b - 30);
    end

    logic [63:0] w_tr;
    assign w_tr = r_r | (64'd1 << {r_cnt[4:0], 1'b0});
    logic [62:0] w_rs;
    assign w_rs = {r_rem[61:0], r_num[61]};
    logic [32:0] w_rmax;
    assign w_rmax = (r_r[31:0] == 32'd0) ? 33'd1 : {1'b0, r_r[31:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_axis <= 2'd0;
            r_busy <= 1'b0;
            r_out_cnt <= 2'd0;
        end else begin
            if (i_cmd.load) begin
                r_axis <= i_axis;
                r_ep <= 33'(signed'(i_meas_pos)) - 33'(signed'(i_target_pos));
                r_ev <= 33'(signed'(i_meas_vel)) - 33'(signed'(i_target_vel));
                r_kp <= i_pos_gains[16*i_axis +: 16];
                r_kv <= i_vel_gains[16*i_axis +: 16];
                r_ref[i_axis] <= i_target_acc;
                r_next_axis <= (i_axis == 2'd2) ? 2'd0 : i_axis + 2'd1;
                if (i_axis == 2'd2) begin
                    r_lim <= i_max_fb;
                    r_grav <= i_gravity_z;
                    r_ft <= i_feedthrough;
                end
            end
            if (i_cmd.mul) begin
                r_pp <= r_ep * signed'({1'b0, r_kp});
                r_pv <= r_ev * signed'({1'b0, r_kv});
            end
            if (i_cmd.fb) begin
                if (w_sh > 52'sh7F_FFFF_FFFF) r_fb[r_axis] <= 40'sh7F_FFFF_FFFF;
                else if (w_sh < -52'sh80_0000_0000) r_fb[r_axis] <= 40'sh80_0000_0000;
                else r_fb[r_axis] <= w_sh[39:0];
                r_limited <= 1'b0;
            end
            if (i_cmd.scale) begin
                for (int j = 0; j < 3; j++) begin
                    r_mag[j] <= 31'(w_abs[j] >> w_k);
                    r_neg[j] <= r_fb[j][FB_W-1];
                end
                r_k <= (w_k != 4'd0);
                r_s <= '0;
                r_i <= 2'd0;
            end
            if (i_cmd.sq) begin
                r_s <= r_s + 64'(r_mag[r_i] * r_mag[r_i]);
                r_i <= r_i + 2'd1;
            end
            if (i_cmd.cmp) r_limited <= o_sts.need_limit;
            if (i_cmd.sqrt_start) begin
                r_x <= r_s;
                r_r <= '0;
                r_cnt <= 6'd31;
            end else if (i_cmd.sqrt_step && !o_sts.sqrt_done) begin
                if (r_x >= w_tr) begin
                    r_x <= r_x - w_tr;
                    r_r <= (r_r >> 1) | (64'd1 << {r_cnt[4:0], 1'b0});
                end else r_r <= r_r >> 1;
                r_cnt <= r_cnt - 6'd1;
            end
            if (i_cmd.div_start) r_i <= 2'd0;
            if (i_cmd.div_start || i_cmd.div_next) begin
                r_num <= r_mag[i_cmd.div_next ? r_i + 2'd1 : 2'd0] * r_lim;
                r_rem <= '0;
                r_q <= '0;
                r_cnt <= 6'd62;
                if (i_cmd.div_next) r_i <= r_i + 2'd1;
            end else if (i_cmd.div_step && !o_sts.div_done) begin
                if (w_rs >= 63'(w_rmax)) begin
                    r_rem <= 62'(w_rs - 63'(w_rmax));
                    r_q <= {r_q[30:0], 1'b1};
                end else begin
                    r_rem <= w_rs[61:0];
                    r_q <= {r_q[30:0], 1'b0};
                end
                r_num <= {r_num[60:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) r_scaled[r_i] <= 31'({r_q[30:0], w_rs >= 63'(w_rmax)});
            end
            if (i_cmd.out_load) begin
                for (int j = 0; j < 3; j++) begin
                    logic signed [42:0] v;
                    logic signed [40:0] f;
                    f = r_limited ? (r_neg[j] ? -41'(r_scaled[j]) : 41'(r_scaled[j]))
                                  : 41'(r_fb[j]);
                    v = r_ft ? 43'(r_ref[j]) : 43'(f) + 43'(r_ref[j])
                        - ((j == 2) ? 43'(r_grav) : 43'sd0);
                    if (v > 43'sh7FFF_FFFF) r_res[j] <= 32'h7FFF_FFFF;
                    else if (v < -43'sh8000_0000) r_res[j] <= 32'h8000_0000;
                    else r_res[j] <= v[31:0];
                end
                r_busy <= 1'b1;
                r_out_cnt <= 2'd0;
            end else if (i_out_taken) begin
                r_out_cnt <= r_out_cnt + 2'd1;
                if (r_out_cnt == 2'd2) r_busy <= 1'b0;
            end
        end
    end

    assign o_sts.is_z = (r_axis == 2'd2);
    assign o_sts.ft = r_ft;
    assign o_sts.sq_done = (r_i == 2'd2);
    assign o_sts.need_limit = r_k || (r_s > 64'(r_lim) * 64'(r_lim));
    assign o_sts.sqrt_done = r_cnt[5];
    assign o_sts.div_done = (r_cnt == 6'd0);
    assign o_sts.div_all = (r_i == 2'd2);

    assign o_out_busy = r_busy;
    assign o_out_axis = r_out_cnt;
    assign o_desired_acc = r_res[r_out_cnt];
    assign o_was_limited = r_limited && !r_ft;
    assign o_last = (r_out_cnt == 2'd2);
endmodule
`default_nettype wire

// File: sim/pdac_checker.sv
`timescale 1ns / 100ps
// Watches the input, output and register write channels of the block.
// Predicts the desired accelerations for each accepted transaction and
// compares every output transaction with the oldest prediction.
module pdac_checker
    import pdac_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [1:0]  i_axis,
    input  wire logic [31:0] i_meas_pos,
    input  wire logic [31:0] i_meas_vel,
    input  wire logic [31:0] i_target_pos,
    input  wire logic [31:0] i_target_vel,
    input  wire logic [31:0] i_target_acc,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [1:0]  i_out_axis,
    input  wire logic [31:0] i_desired_acc,
    input  wire logic        i_was_limited,
    input  wire logic        i_last,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [47:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending,
    output int               o_results,
    output int               o_limited
);
    localparam longint FB_HI = (64'sd1 <<< (FB_W - 1)) - 1;
    localparam longint FB_LO = -(64'sd1 <<< (FB_W - 1));

    typedef struct {
        logic [1:0]  axis;
        logic [31:0] acc;
        logic        limited;
        logic        last;
    } t_accel;

    t_accel      accel_q[$];

    logic [47:0] kp_packed, kv_packed;
    logic [30:0] fb_limit;
    logic [31:0] gravity;
    logic        feedthru;
    longint      fb_axis[3];
    longint      ref_axis[3];
    logic [1:0]  axis_due;

    function automatic longint to_s32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] s);
        logic [63:0] r, t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= s) r = t;
        end
        return r;
    endfunction

    // one accepted transaction: update stores, queue the run's results on z
    task automatic predict_accel();
        logic [1:0]  ax;
        longint      kp, kv, ep, ev, fb, v;
        logic [63:0] mag[3], mx, sq, root, lim;
        logic        neg[3], limited;
        longint      f[3];
        int          k;
        t_accel      e;
        ax = i_axis;
        if (ax != 2'd0 && ax != axis_due) return;
        kp = longint'(kp_packed[16*ax +: 16]);
        kv = longint'(kv_packed[16*ax +: 16]);
        ep = to_s32(i_meas_pos) - to_s32(i_target_pos);
        ev = to_s32(i_meas_vel) - to_s32(i_target_vel);
        fb = (-(kp * ep + kv * ev)) >>> 8;
        if (fb > FB_HI) fb = FB_HI;
        if (fb < FB_LO) fb = FB_LO;
        fb_axis[ax]  = fb;
        ref_axis[ax] = to_s32(i_target_acc);
        if (ax != 2'd2) begin
            axis_due = ax + 2'd1;
            return;
        end
        axis_due = 2'd0;
        limited  = 1'b0;
        for (int i = 0; i < 3; i++) f[i] = fb_axis[i];
        if (!feedthru) begin
            mx = 0;
            for (int i = 0; i < 3; i++) begin
                neg[i] = f[i] < 0;
                mag[i] = neg[i] ? 64'(-f[i]) : 64'(f[i]);
                if (mag[i] > mx) mx = mag[i];
            end
            k = 0;
            while ((mx >> k) >= (64'd1 << 31)) k++;
            sq = 0;
            for (int i = 0; i < 3; i++) begin
                mag[i] = mag[i] >> k;
                sq += mag[i] * mag[i];
            end
            lim = 64'(fb_limit);
            if (k > 0 || sq > lim * lim) begin
                limited = 1'b1;
                root = floor_root(sq);
                if (root == 0) root = 1;
                for (int i = 0; i < 3; i++)
                    f[i] = neg[i] ? -longint'(mag[i] * lim / root)
                                  : longint'(mag[i] * lim / root);
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (feedthru) begin
                v = ref_axis[i];
            end else begin
                v = f[i] + ref_axis[i];
                if (i == 2) v -= to_s32(gravity);
            end
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            e.axis    = 2'(i);
            e.acc     = v[31:0];
            e.limited = limited;
            e.last    = (i == 2);
            accel_q.push_back(e);
        end
    endtask

    task automatic compare_accel();
        t_accel e;
        if (accel_q.size() == 0) begin
            $display("%0t: unexpected result axis=%0d acc=%h lim=%b last=%b", $time,
                     i_out_axis, i_desired_acc, i_was_limited, i_last);
            o_errors++;
            return;
        end
        e = accel_q.pop_front();
        o_results++;
        if (i_was_limited) o_limited++;
        if (i_out_axis != e.axis || i_desired_acc != e.acc
                || i_was_limited != e.limited || i_last != e.last) begin
            $display("%0t: mismatch expected axis=%0d acc=%h lim=%b last=%b", $time,
                     e.axis, e.acc, e.limited, e.last);
            $display("%0t:          actual   axis=%0d acc=%h lim=%b last=%b", $time,
                     i_out_axis, i_desired_acc, i_was_limited, i_last);
            o_errors++;
        end
    endtask

    initial begin
        o_errors  = 0;
        o_results = 0;
        o_limited = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            kp_packed = 48'd4398080066048;
            kv_packed = 48'd4398113620992;
            fb_limit  = 31'd655360;
            gravity   = 32'hFFF6_3333;   // -642253
            feedthru  = 1'b0;
            axis_due  = 2'd0;
            accel_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_POS_GAINS: kp_packed = i_cfg_data;
                    REG_VEL_GAINS: kv_packed = i_cfg_data;
                    REG_MAX_FB:    fb_limit  = i_cfg_data[30:0];
                    REG_GRAVITY:   gravity   = i_cfg_data[31:0];
                    REG_FEEDTHRU:  feedthru  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) compare_accel();
            if (i_in_valid && i_in_ready) predict_accel();
        end
        o_pending = accel_q.size();
    end
endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Stimulus and verdict for pd_position_accel_command; all checking sits in
// pdac_checker.
module tb_top;
    import pdac_pkg::*;

    localparam logic [1:0] AX_X   = 2'd0;
    localparam logic [1:0] AX_Y   = 2'd1;
    localparam logic [1:0] AX_Z   = 2'd2;
    localparam logic [1:0] AX_BAD = 2'd3;

    localparam int SETTLE_CYCLES = 400;
    localparam int CYCLE_LIMIT   = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_axis = '0;
    logic [31:0] i_meas_pos = '0, i_meas_vel = '0;
    logic [31:0] i_target_pos = '0, i_target_vel = '0, i_target_acc = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_out_axis;
    logic [31:0] o_desired_acc;
    logic        o_was_limited, o_last;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [47:0] i_cfg_data = '0;

    int  errors, pending, results, limited_results;
    int  cycles = 0;
    int  transactions = 0;
    bit  calm = 1'b0;   // no gaps and no stalls while set

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    pd_position_accel_command uut (.*);

    pdac_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_axis,
        .i_meas_pos, .i_meas_vel, .i_target_pos, .i_target_vel, .i_target_acc,
        .i_out_valid(o_out_valid), .i_out_ready, .i_out_axis(o_out_axis),
        .i_desired_acc(o_desired_acc), .i_was_limited(o_was_limited), .i_last(o_last),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_limited(limited_results)
    );

    // mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stalls
    always @(negedge i_clk) begin
        int stall;
        stall = pick_gap();
        if (stall > 0) begin
            i_out_ready <= 1'b0;
            repeat (stall) @(negedge i_clk);
        end
        i_out_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("pd_position_accel_command verification failed");
            $finish;
        end
    end

    // one input transaction; valid stays up into the next one if no gap
    task automatic send_axis(logic [1:0] ax, logic [31:0] mp, logic [31:0] mv,
                             logic [31:0] tp, logic [31:0] tv, logic [31:0] ta);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_axis       <= ax;
        i_meas_pos   <= mp;
        i_meas_vel   <= mv;
        i_target_pos <= tp;
        i_target_vel <= tv;
        i_target_acc <= ta;
        do @(posedge i_clk); while (!o_in_ready);
        transactions++;
    endtask

    function automatic logic [31:0] pick_val(bit wide);
        if (wide) return $urandom;
        return 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
    endfunction

    task automatic send_random(logic [1:0] ax, bit wide);
        send_axis(ax, pick_val(wide), pick_val(wide), pick_val(wide),
                  pick_val(wide), pick_val(wide));
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] data);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // all results in, then let any x/y or dropped transaction finish
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_regs(logic [47:0] kp, logic [47:0] kv, logic [30:0] lim,
                            logic [31:0] grav, logic ft);
        settle();
        write_reg(REG_POS_GAINS, kp);
        write_reg(REG_VEL_GAINS, kv);
        write_reg(REG_MAX_FB, 48'(lim));
        write_reg(REG_GRAVITY, 48'(grav));
        write_reg(REG_FEEDTHRU, 48'(ft));
    endtask

    // mostly ordered runs with random content, some noise and broken runs
    task automatic random_phase(int runs);
        bit wide;
        for (int n = 0; n < runs; n++) begin
            wide = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 7) == 0) begin
                send_random(2'($urandom_range(0, 3)), wide);
            end else begin
                send_random(AX_X, wide);
                if ($urandom_range(0, 9) == 0) send_random(AX_Z, wide);   // skipped y
                send_random(AX_Y, wide);
                send_random(AX_Z, wide);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset gains: small error, under the limit
        calm = 1'b1;
        send_axis(AX_X, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0000_8000);
        send_axis(AX_Y, 32'h0, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0);
        send_axis(AX_Z, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000);
        calm = 1'b0;
        // out of order: lone y, lone z, axis three all dropped
        send_axis(AX_Y, 32'h1234, 32'h0, 32'h0, 32'h0, 32'h0);
        send_axis(AX_Z, 32'h1234, 32'h0, 32'h0, 32'h0, 32'h0);
        send_axis(AX_BAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
        // x restarting a run, then full-scale errors forcing a pre-shift
        send_axis(AX_X, 32'h5555_5555, 32'h0, 32'h0, 32'h0, 32'h0);
        send_axis(AX_X, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF);
        send_axis(AX_Y, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000);
        send_axis(AX_Z, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF);
        // z straight after x is dropped, y then z completes the run
        send_axis(AX_X, 32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
        send_axis(AX_Z, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_axis(AX_Y, 32'h0, 32'h0005_0000, 32'h0, 32'h0, 32'h0);
        send_axis(AX_Z, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000);

        // maximum gains, zero limit, extreme gravity: saturating sums
        set_regs(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 31'd0, 32'h7FFF_FFFF, 1'b0);
        send_axis(AX_X, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000);   // zero vector
        send_axis(AX_Y, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_axis(AX_Z, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
        random_phase(6);

        // feedthrough with minimum gravity, which must not show
        set_regs(48'($urandom) << 16 | 48'($urandom), 48'($urandom), 31'd655360,
                 32'h8000_0000, 1'b1);
        random_phase(6);

        // zero gains, widest limit
        set_regs(48'h0, 48'h0, 31'h7FFF_FFFF, 32'h0, 1'b0);
        random_phase(8);

        // random settings, twice
        for (int p = 0; p < 2; p++) begin
            set_regs({16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
                     31'($urandom_range(0, 32'h0040_0000)), $urandom, 1'b0);
            random_phase(6);
        end

        settle();
        $display("%0d input transactions, %0d results checked (%0d with feedback limited)",
                 transactions, results, limited_results);
        $display("register settings: reset, extremes, feedthrough, zero gains, random");
        if (errors == 0) begin
            $display("pd_position_accel_command verification clean");
        end else begin
            $display("pd_position_accel_command verification failed");
        end
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/pdac_pkg.sv
hw/rtl/pdac_ctrl.sv
hw/rtl/pdac_dp.sv
hw/rtl/pd_position_accel_command.sv
sim/pdac_checker.sv
sim/tb_top.sv
